[hdl/lfss_pkg.sv]
// lfss_pkg: shared types and constants of the line follower steering/speed loop.
// Microcode control word, datapath select codes and register indexes.
// No dependencies.
`default_nettype none

package lfss_pkg;

  localparam int PC_W  = 5;
  localparam int CFG_W = 16;
  localparam int IDX_W = 3;

  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [IDX_W-1:0] cfg_index_t;

  // Register indexes
  localparam cfg_index_t REG_STEER_KP      = 3'd0;
  localparam cfg_index_t REG_STEER_KI      = 3'd1;
  localparam cfg_index_t REG_STEER_KD      = 3'd2;
  localparam cfg_index_t REG_LEFT_GAIN     = 3'd3;
  localparam cfg_index_t REG_RIGHT_GAIN    = 3'd4;
  localparam cfg_index_t REG_LEFT_BASE     = 3'd5;
  localparam cfg_index_t REG_RIGHT_BASE    = 3'd6;
  localparam cfg_index_t REG_TICKS_PER_SEC = 3'd7;

  // Reset values
  localparam logic [15:0] STEER_KP_RESET   = 16'd7;
  localparam logic [15:0] STEER_KI_RESET   = 16'd0;
  localparam logic [15:0] STEER_KD_RESET   = 16'd0;
  localparam logic [15:0] LEFT_GAIN_RESET  = 16'd201;
  localparam logic [15:0] RIGHT_GAIN_RESET = 16'd159;
  localparam logic [15:0] BASE_RESET       = 16'd1500;
  localparam logic [9:0]  TPS_RESET        = 10'd100;
  localparam logic [15:0] TARGET_RESET     = 16'd2000;

  // Microcode entry of the speed update
  localparam pc_t SPEED_ENTRY = 5'd8;

  typedef enum logic [2:0] {
    A_KP, A_KI, A_KD, A_TPS, A_LGAIN, A_RGAIN
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ERR, B_INTEG, B_DERR, B_LPULSE, B_RPULSE, B_DIFF
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_ERR, OP_TGT, OP_LDIFF, OP_RDIFF, OP_LDUTY, OP_RDUTY, OP_OUT
  } op_t;

  typedef enum logic {
    JMP_NONE, JMP_SPEED
  } jmp_t;

  typedef struct packed {
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    logic    mul_en;
    acc_op_t acc_op;
    op_t     op;
    jmp_t    jmp;
    pc_t     jmp_to;
    logic    last;
  } ctrl_t;

endpackage

`default_nettype wire

[hdl/lfss_ucode.sv]
// lfss_ucode: microcode ROM, one control word per step.
// Depends on lfss_pkg.
`default_nettype none

module lfss_ucode
  import lfss_pkg::*;
(
  input  pc_t   pc,
  output ctrl_t ctrl
);

  always_comb begin
    ctrl = '{a_sel: A_KP, b_sel: B_ERR, mul_en: 1'b0, acc_op: ACC_HOLD,
             op: OP_NONE, jmp: JMP_NONE, jmp_to: '0, last: 1'b0};
    case (pc)
      // dispatch on the captured action
      5'd0: begin
        ctrl.jmp    = JMP_SPEED;
        ctrl.jmp_to = SPEED_ENTRY;
      end
      // steering: error, then kp*e, ki*i, kd*de into the accumulator
      5'd1: ctrl.op = OP_ERR;
      5'd2: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_KP; ctrl.b_sel = B_ERR;
      end
      5'd3: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_KI; ctrl.b_sel = B_INTEG;
        ctrl.acc_op = ACC_LOAD;
      end
      5'd4: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_KD; ctrl.b_sel = B_DERR;
        ctrl.acc_op = ACC_ADD;
      end
      5'd5: ctrl.acc_op = ACC_ADD;
      5'd6: ctrl.op = OP_TGT;
      5'd7: begin
        ctrl.op = OP_OUT; ctrl.last = 1'b1;
      end
      // speed: left wheel, then right wheel
      5'd8: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_TPS; ctrl.b_sel = B_LPULSE;
      end
      5'd9: ctrl.op = OP_LDIFF;
      5'd10: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_LGAIN; ctrl.b_sel = B_DIFF;
      end
      5'd11: ctrl.op = OP_LDUTY;
      5'd12: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_TPS; ctrl.b_sel = B_RPULSE;
      end
      5'd13: ctrl.op = OP_RDIFF;
      5'd14: begin
        ctrl.mul_en = 1'b1; ctrl.a_sel = A_RGAIN; ctrl.b_sel = B_DIFF;
      end
      5'd15: ctrl.op = OP_RDUTY;
      5'd16: begin
        ctrl.op = OP_OUT; ctrl.last = 1'b1;
      end
      default: ctrl.last = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

[hdl/lfss_datapath.sv]
// lfss_datapath: config registers, input capture, shared multiplier,
// accumulator, loop state and output registers, driven by the control word.
// Depends on lfss_pkg.
`default_nettype none

module lfss_datapath
  import lfss_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int DUTY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  cfg_index_t          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                load,
  input  logic                action,
  input  logic [ADC_BITS-1:0] sensor_a,
  input  logic [ADC_BITS-1:0] sensor_b,
  input  logic [ADC_BITS-1:0] sensor_c,
  input  logic [ADC_BITS-1:0] sensor_d,
  input  logic [ADC_BITS-1:0] sensor_e,
  input  logic [ADC_BITS-1:0] sensor_f,
  input  logic signed [15:0]  left_pulses,
  input  logic signed [15:0]  right_pulses,
  input  logic                step_en,
  input  ctrl_t               ctrl,
  output logic                action_q,
  output logic [15:0]         left_drive,
  output logic [15:0]         right_drive,
  output logic signed [15:0]  left_target_out,
  output logic signed [15:0]  right_target_out
);

  localparam int ESW    = (ADC_BITS + 6 > 19) ? ADC_BITS + 6 : 19;
  localparam int PROD_W = 49;
  localparam int ACC_W  = 50;
  localparam int TS_W   = ACC_W + 1;
  localparam int DIFF_W = 29;
  localparam int ND_W   = 42;

  // config
  logic signed [15:0] steer_kp, steer_ki, steer_kd;
  logic [15:0]        left_speed_gain, right_speed_gain;
  logic signed [15:0] left_base_speed, right_base_speed;
  logic [9:0]         ticks_per_second;

  // captured item
  logic [ADC_BITS-1:0] sa, sb, sc, sd, se, sf;
  logic signed [15:0]  lpulse, rpulse;

  // loop state
  logic signed [31:0]        steer_integral;
  logic signed [17:0]        prev_steer_error;
  logic signed [17:0]        err;
  logic signed [15:0]        left_target, right_target;
  logic [DUTY_BITS-1:0]      left_duty, right_duty;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [DIFF_W-1:0]  diff;

  logic signed [16:0]        mul_a;
  logic signed [31:0]        mul_b;
  logic signed [PROD_W-1:0]  prod_next;

  logic signed [ESW-1:0]     ea, eb, ec, ed, ee, ef, err_sum;
  logic signed [17:0]        err_next;
  logic signed [18:0]        derr;
  logic signed [32:0]        isum;
  logic signed [31:0]        integ_next;
  logic signed [ACC_W-1:0]   corr;
  logic signed [TS_W-1:0]    lt_sum, rt_sum;
  logic signed [15:0]        tgt_sel;
  logic signed [DIFF_W-1:0]  diff_next;
  logic [DUTY_BITS-1:0]      duty_sel, duty_next, ldrive_inv, rdrive_inv;
  logic signed [ND_W-1:0]    duty_ext, nd;

  function automatic logic signed [15:0] sat16(input logic signed [TS_W-1:0] v);
    if (v[TS_W-1:15] == '0 || v[TS_W-1:15] == '1) begin
      return v[15:0];
    end
    return v[TS_W-1] ? 16'sh8000 : 16'sh7fff;
  endfunction

  // weighted line error, doubled weights 10, 5, 2
  always_comb begin
    ea = signed'(ESW'(sa));
    eb = signed'(ESW'(sb));
    ec = signed'(ESW'(sc));
    ed = signed'(ESW'(sd));
    ee = signed'(ESW'(se));
    ef = signed'(ESW'(sf));
    err_sum = (ea <<< 3) + (ea <<< 1) + (eb <<< 2) + eb + (ec <<< 1)
            - (ed <<< 1) - (ee <<< 2) - ee - (ef <<< 3) - (ef <<< 1);
    if (err_sum[ESW-1:17] == '0 || err_sum[ESW-1:17] == '1) begin
      err_next = err_sum[17:0];
    end else begin
      err_next = err_sum[ESW-1] ? 18'sh20000 : 18'sh1ffff;
    end
    isum = 33'(steer_integral) + 33'(err_next);
    if (isum[32] != isum[31]) begin
      integ_next = isum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      integ_next = isum[31:0];
    end
  end

  assign derr = 19'(err) - 19'(prev_steer_error);

  // shared multiplier operands
  always_comb begin
    case (ctrl.a_sel)
      A_KP:    mul_a = 17'(steer_kp);
      A_KI:    mul_a = 17'(steer_ki);
      A_KD:    mul_a = 17'(steer_kd);
      A_TPS:   mul_a = signed'({7'd0, ticks_per_second});
      A_LGAIN: mul_a = signed'({1'b0, left_speed_gain});
      A_RGAIN: mul_a = signed'({1'b0, right_speed_gain});
      default: mul_a = '0;
    endcase
    case (ctrl.b_sel)
      B_ERR:    mul_b = 32'(err);
      B_INTEG:  mul_b = steer_integral;
      B_DERR:   mul_b = 32'(derr);
      B_LPULSE: mul_b = 32'(lpulse);
      B_RPULSE: mul_b = 32'(rpulse);
      B_DIFF:   mul_b = 32'(diff);
      default:  mul_b = '0;
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // arithmetic shift gives the floor of the division by 256
  assign corr   = acc >>> 8;
  assign lt_sum = TS_W'(left_base_speed) - TS_W'(corr);
  assign rt_sum = TS_W'(right_base_speed) + TS_W'(corr);

  assign tgt_sel   = (ctrl.op == OP_RDIFF) ? right_target : left_target;
  assign diff_next = DIFF_W'(tgt_sel) - DIFF_W'(prod);

  assign duty_sel = (ctrl.op == OP_RDUTY) ? right_duty : left_duty;
  assign duty_ext = signed'(ND_W'(duty_sel));
  assign nd       = duty_ext + ND_W'(prod >>> 8);

  always_comb begin
    if (nd[ND_W-1]) begin
      duty_next = '0;
    end else if (nd[ND_W-1:DUTY_BITS] != '0) begin
      duty_next = '1;
    end else begin
      duty_next = nd[DUTY_BITS-1:0];
    end
  end

  assign ldrive_inv = ~left_duty;
  assign rdrive_inv = ~right_duty;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_kp         <= STEER_KP_RESET;
      steer_ki         <= STEER_KI_RESET;
      steer_kd         <= STEER_KD_RESET;
      left_speed_gain  <= LEFT_GAIN_RESET;
      right_speed_gain <= RIGHT_GAIN_RESET;
      left_base_speed  <= BASE_RESET;
      right_base_speed <= BASE_RESET;
      ticks_per_second <= TPS_RESET;
      steer_integral   <= '0;
      prev_steer_error <= '0;
      left_target      <= TARGET_RESET;
      right_target     <= TARGET_RESET;
      left_duty        <= '0;
      right_duty       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEER_KP:      steer_kp         <= cfg_data;
          REG_STEER_KI:      steer_ki         <= cfg_data;
          REG_STEER_KD:      steer_kd         <= cfg_data;
          REG_LEFT_GAIN:     left_speed_gain  <= cfg_data;
          REG_RIGHT_GAIN:    right_speed_gain <= cfg_data;
          REG_LEFT_BASE:     left_base_speed  <= cfg_data;
          REG_RIGHT_BASE:    right_base_speed <= cfg_data;
          REG_TICKS_PER_SEC: ticks_per_second <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (step_en) begin
        case (ctrl.op)
          OP_ERR:   steer_integral <= integ_next;
          OP_TGT: begin
            prev_steer_error <= err;
            left_target      <= sat16(lt_sum);
            right_target     <= sat16(rt_sum);
          end
          OP_LDUTY: left_duty  <= duty_next;
          OP_RDUTY: right_duty <= duty_next;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      action_q <= action;
      sa <= sensor_a; sb <= sensor_b; sc <= sensor_c;
      sd <= sensor_d; se <= sensor_e; sf <= sensor_f;
      lpulse <= left_pulses;
      rpulse <= right_pulses;
    end
    if (step_en) begin
      if (ctrl.mul_en) begin
        prod <= prod_next;
      end
      case (ctrl.acc_op)
        ACC_LOAD: acc <= ACC_W'(prod);
        ACC_ADD:  acc <= acc + ACC_W'(prod);
        default: ;
      endcase
      case (ctrl.op)
        OP_ERR:   err  <= err_next;
        OP_LDIFF: diff <= diff_next;
        OP_RDIFF: diff <= diff_next;
        OP_OUT: begin
          left_drive       <= 16'(ldrive_inv);
          right_drive      <= 16'(rdrive_inv);
          left_target_out  <= left_target;
          right_target_out <= right_target;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/line_follow_steer_speed_loop.sv]
// line_follow_steer_speed_loop: top level, step counter and handshakes.
// Depends on lfss_pkg, lfss_ucode, lfss_datapath.
//
//   channel   signals                                   direction
//   input     in_valid/in_stall, action, sensor_a..f,   in (in_stall out)
//             left_pulses, right_pulses
//   output    out_valid/out_stall, left_drive,          out (out_stall in)
//             right_drive, left_target_out, right_target_out
//   config    cfg_write, cfg_index, cfg_data            in
//
// One item at a time: a steering update and a speed update each run for the
// length of their microcode, through the one shared 17x32 multiplier.
// The next item is taken in the cycle of the last step.
// rst is synchronous; it restores the register reset values and loop state.
// A stalled result holds the sequencer at its publish step; the item after it
// may already be captured while the result waits.
`default_nettype none

module line_follow_steer_speed_loop
  import lfss_pkg::*;
#(
  parameter int ADC_BITS  = 12,
  parameter int DUTY_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [ADC_BITS-1:0] sensor_a,
  input  logic [ADC_BITS-1:0] sensor_b,
  input  logic [ADC_BITS-1:0] sensor_c,
  input  logic [ADC_BITS-1:0] sensor_d,
  input  logic [ADC_BITS-1:0] sensor_e,
  input  logic [ADC_BITS-1:0] sensor_f,
  input  logic signed [15:0]  left_pulses,
  input  logic signed [15:0]  right_pulses,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         left_drive,
  output logic [15:0]         right_drive,
  output logic signed [15:0]  left_target_out,
  output logic signed [15:0]  right_target_out,
  input  logic                cfg_write,
  input  cfg_index_t          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  logic  busy;
  pc_t   pc;
  ctrl_t ctrl;
  logic  action_q;
  logic  hold;
  logic  step_en;
  logic  accept;

  lfss_ucode u_ucode (
    .pc   (pc),
    .ctrl (ctrl)
  );

  // publish waits until the output register is free
  assign hold     = (ctrl.op == OP_OUT) && out_valid && out_stall;
  assign step_en  = busy && !hold;
  assign in_stall = busy && !(step_en && ctrl.last);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step_en && ctrl.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (step_en) begin
        if (ctrl.last) begin
          busy <= 1'b0;
        end else if (ctrl.jmp == JMP_SPEED && action_q) begin
          pc <= ctrl.jmp_to;
        end else begin
          pc <= pc + 1'b1;
        end
      end
    end
  end

  lfss_datapath #(
    .ADC_BITS  (ADC_BITS),
    .DUTY_BITS (DUTY_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .load             (accept),
    .action           (action),
    .sensor_a         (sensor_a),
    .sensor_b         (sensor_b),
    .sensor_c         (sensor_c),
    .sensor_d         (sensor_d),
    .sensor_e         (sensor_e),
    .sensor_f         (sensor_f),
    .left_pulses      (left_pulses),
    .right_pulses     (right_pulses),
    .step_en          (step_en),
    .ctrl             (ctrl),
    .action_q         (action_q),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .left_target_out  (left_target_out),
    .right_target_out (right_target_out)
  );

endmodule

`default_nettype wire
